@@ rtl/olip_pkg.sv @@
package olip_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_EMPTY,
      OUT_HEAD
   } out_sel_type;

   // controller to datapath, one per accepted item
   typedef struct packed {
      logic        load;     // item accepted this cycle
      logic        insert;   // place key at the insert index
      logic        pop;      // move each cell but the last forward by one
      out_sel_type out_sel;  // source of the result data
   } dp_cmd_type;

endpackage

@@ rtl/olip_ctrl.sv @@
module olip_ctrl #(
   parameter int DEPTH = olip_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [CNT_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output olip_pkg::dp_cmd_type   cmd,
   output logic [IDX_W-1:0]       ins_idx
);

   typedef enum logic {
      S_IDLE,
      S_HOLD
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       status_ff, status_in;
   logic             accept;
   logic             is_full;
   logic             is_empty;
   logic             pos_bad;

   assign req_stall = (state_ff == S_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);
   assign pos_bad   = (req_position == '0) || (req_position > count_ff);

   always_comb begin
      cmd.load    = accept;
      cmd.insert  = 1'b0;
      cmd.pop     = 1'b0;
      cmd.out_sel = olip_pkg::OUT_ZERO;
      ins_idx     = '0;
      count_in    = count_ff;
      status_in   = status_ff;
      if (accept) begin
         status_in = olip_pkg::STATUS_OK;
         unique case (req_opcode)
            olip_pkg::OP_PUSH: begin
               if (is_full) begin
                  status_in = olip_pkg::STATUS_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            olip_pkg::OP_INSERT: begin
               priority if (is_full) begin
                  status_in = olip_pkg::STATUS_FULL;
               end else if (pos_bad) begin
                  status_in = olip_pkg::STATUS_RANGE;
               end else begin
                  cmd.insert = 1'b1;
                  ins_idx    = IDX_W'(req_position - 1'b1);
                  count_in   = count_ff + 1'b1;
               end
            end
            olip_pkg::OP_POP: begin
               if (is_empty) begin
                  status_in   = olip_pkg::STATUS_EMPTY;
                  cmd.out_sel = olip_pkg::OUT_EMPTY;
               end else begin
                  cmd.pop     = 1'b1;
                  cmd.out_sel = olip_pkg::OUT_HEAD;
                  count_in    = count_ff - 1'b1;
               end
            end
            default: begin
               // no operation
            end
         endcase
      end
   end

   always_comb begin
      priority if (accept) begin
         state_in = S_HOLD;
      end else if (state_ff == S_HOLD && rsp_stall) begin
         state_in = S_HOLD;
      end else begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         status_ff <= olip_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = (state_ff == S_HOLD);
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

endmodule

@@ rtl/olip_dpath.sv @@
module olip_dpath #(
   parameter int DEPTH = olip_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  olip_pkg::dp_cmd_type  cmd,
   input  logic [IDX_W-1:0]      ins_idx,
   input  logic signed [31:0]    req_key_value,
   output logic signed [31:0]    rsp_data_out
);

   logic signed [31:0] cell_ff [DEPTH];
   logic signed [31:0] cell_in [DEPTH];
   logic signed [31:0] data_ff, data_in;

   // each cell looks only at itself and its two neighbors
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (IDX_W'(i) == ins_idx) begin
               cell_in[i] = req_key_value;
            end else if (i > 0 && IDX_W'(i) > ins_idx) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.pop && i < DEPTH - 1) begin
            cell_in[i] = cell_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      data_in = data_ff;
      if (cmd.load) begin
         unique case (cmd.out_sel)
            olip_pkg::OUT_EMPTY: data_in = olip_pkg::EMPTY_VALUE;
            olip_pkg::OUT_HEAD:  data_in = cell_ff[0];
            default:             data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      data_ff <= data_in;
   end

   assign rsp_data_out = data_ff;

endmodule

@@ rtl/ordered_list_insert_pop.sv @@
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | opcode, key_value, position
// rsp      | out       | rsp_valid/rsp_stall  | data_out, status, entry_count
//
// One item per cycle unless stalled: the whole chain of cells shifts in
// the accept cycle and the result shows in the output register next cycle.
// Reset clears the count and the result valid; cell contents are unknown
// until written and are never read before that.
// A held result stalls the input only while rsp_stall is high.
module ordered_list_insert_pop #(
   parameter int DEPTH = olip_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic signed [31:0]  req_key_value,
   input  logic [CNT_W-1:0]    req_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_data_out,
   output logic [1:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_entry_count
);

   // command from the controller to the cell chain
   olip_pkg::dp_cmd_type cmd;
   logic [IDX_W-1:0]     ins_idx;

   // controller: count, status decision, result handshake
   olip_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .cmd             (cmd),
      .ins_idx         (ins_idx)
   );

   // datapath: chain of cells and the result data register
   olip_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock         (clock),
      .cmd           (cmd),
      .ins_idx       (ins_idx),
      .req_key_value (req_key_value),
      .rsp_data_out  (rsp_data_out)
   );

endmodule

@@ verif/ordered_list_insert_pop_test.sv @@
`timescale 1ns / 1ps

module ordered_list_insert_pop_test;

   localparam int LIST_DEPTH = olip_pkg::DEPTH_DEFAULT;

   // one expected item on the result channel
   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [4:0]         count;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode = olip_pkg::OP_NOP;
   logic signed [31:0] req_key_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_data_out;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_entry_count;

   // our own copy of the list, advanced once per accepted item
   logic signed [31:0] list_store [LIST_DEPTH];
   int                 list_count = 0;
   list_result_type    expected_results [$];

   int                 fail_count = 0;
   int                 items_sent = 0;
   bit                 idle_on = 1'b1;

   ordered_list_insert_pop i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_key_value   (req_key_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_out    (rsp_data_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // List prediction
   // ---------------------------------------------------------------------

   // Put key at slot, moving every later entry back by one cell.
   function automatic void place_entry(int slot, logic signed [31:0] key);
      for (int i = list_count; i > slot; i--)
         list_store[i] = list_store[i - 1];
      list_store[slot] = key;
      list_count++;
   endfunction

   // Apply one operation to the list copy and return the item it must produce.
   function automatic list_result_type apply_op(logic [1:0] op, logic signed [31:0] key,
                                                logic [4:0] pos);
      list_result_type r;
      r.data   = '0;
      r.status = olip_pkg::STATUS_OK;
      case (op)
         olip_pkg::OP_PUSH: begin
            // a full list refuses the push and stays as it was
            if (list_count >= LIST_DEPTH)
               r.status = olip_pkg::STATUS_FULL;
            else
               place_entry(0, key);
         end
         olip_pkg::OP_INSERT: begin
            // the full check wins over the position check
            if (list_count >= LIST_DEPTH)
               r.status = olip_pkg::STATUS_FULL;
            else if (pos == 0 || pos > list_count)
               r.status = olip_pkg::STATUS_RANGE;
            else
               place_entry(pos - 1, key);
         end
         olip_pkg::OP_POP: begin
            if (list_count == 0) begin
               r.data   = olip_pkg::EMPTY_VALUE;
               r.status = olip_pkg::STATUS_EMPTY;
            end else begin
               r.data = list_store[0];
               for (int i = 1; i < list_count; i++)
                  list_store[i - 1] = list_store[i];
               list_count--;
            end
         end
         default: begin
            // no operation: count and contents hold
         end
      endcase
      r.count = 5'(list_count);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   // Count every failure, print only the first ten.
   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Compare each item taken from the result channel with the oldest expectation.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected item: data %0d status %0d count %0d",
                                   rsp_data_out, rsp_status, rsp_entry_count));
         end else begin
            want = expected_results.pop_front();
            if (rsp_data_out !== want.data || rsp_status !== want.status ||
                rsp_entry_count !== want.count)
               note_failure($sformatf(
                  "mismatch: data %0d/%0d status %0d/%0d count %0d/%0d (expected/actual)",
                  want.data, rsp_data_out, want.status, rsp_status,
                  want.count, rsp_entry_count));
         end
      end
   end

   // Stall the result channel at random; the stall changes only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 13);
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Send one item: idle a random number of cycles, raise valid, hold the
   // payload until the block takes it, then record the expected result.
   task automatic send_item(logic [1:0] op, logic signed [31:0] key, logic [4:0] pos);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_key_value <= key;
      req_position  <= pos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_results.push_back(apply_op(op, key, pos));
      items_sent++;
   endtask

   // Drop valid and hold the sender until every expected item has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Mostly a legal 1-based position for the current count, sometimes any value.
   function automatic logic [4:0] pick_position();
      if (list_count == 0 || $urandom_range(99) < 15)
         return 5'($urandom_range(31));
      return 5'($urandom_range(list_count, 1));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Extremes of the fields and the refusal cases on a short list.
   task automatic test_directed();
      send_item(olip_pkg::OP_POP, 32'sd5, 5'd1);                 // pop from an empty list
      send_item(olip_pkg::OP_INSERT, 32'sd7, 5'd1);              // insert into an empty list
      send_item(olip_pkg::OP_NOP, -32'sd1, 5'd31);               // no operation
      send_item(olip_pkg::OP_PUSH, 32'sh7FFF_FFFF, 5'd0);        // largest key
      send_item(olip_pkg::OP_PUSH, 32'sh8000_0000, 5'd31);       // smallest key
      send_item(olip_pkg::OP_INSERT, 32'sd11, 5'd0);             // position zero
      send_item(olip_pkg::OP_INSERT, 32'sd12, 5'd3);             // one past the count
      send_item(olip_pkg::OP_INSERT, 32'sd13, 5'd31);            // largest position
      send_item(olip_pkg::OP_INSERT, 32'sd0, 5'd1);              // insert at the head
      send_item(olip_pkg::OP_INSERT, -32'sd1, 5'd3);             // insert before the tail
      send_item(olip_pkg::OP_PUSH, 32'sh5555_5555, 5'd16);
      send_item(olip_pkg::OP_INSERT, 32'shAAAA_AAAA, 5'd16);     // position bit 4
      send_item(olip_pkg::OP_INSERT, 32'sh1234_5678, 5'd5);      // before the last entry
      send_item(olip_pkg::OP_NOP, 32'sh0F0F_0F0F, 5'd2);
      repeat (6)
         send_item(olip_pkg::OP_POP, $urandom, 5'($urandom_range(31)));
      send_item(olip_pkg::OP_POP, 32'sd0, 5'd0);                 // empty again
   endtask

   // Random mix of every operation with random payloads.
   task automatic test_random_mix(int n_items);
      int pick;
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < 30)
            send_item(olip_pkg::OP_PUSH, $urandom, 5'($urandom_range(31)));
         else if (pick < 60)
            send_item(olip_pkg::OP_INSERT, $urandom, pick_position());
         else if (pick < 90)
            send_item(olip_pkg::OP_POP, $urandom, 5'($urandom_range(31)));
         else
            send_item(olip_pkg::OP_NOP, $urandom, 5'($urandom_range(31)));
      end
   endtask

   // Fill the list to full, hit it while full, drain it, pop it while empty;
   // repeat until the item budget is spent.
   task automatic test_fill_drain(int n_items);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < n_items) begin
         // fill: mostly pushes and legal inserts, a few pops and no-ops
         while (list_count < LIST_DEPTH) begin
            pick = $urandom_range(99);
            if (pick < 40 || list_count == 0)
               send_item(olip_pkg::OP_PUSH, $urandom, 5'($urandom_range(31)));
            else if (pick < 85)
               send_item(olip_pkg::OP_INSERT, $urandom, pick_position());
            else if (pick < 95)
               send_item(olip_pkg::OP_POP, $urandom, 5'($urandom_range(31)));
            else
               send_item(olip_pkg::OP_NOP, $urandom, 5'($urandom_range(31)));
         end
         // full list: every push and insert is refused
         repeat ($urandom_range(3, 1))
            send_item($urandom_range(1) ? olip_pkg::OP_INSERT : olip_pkg::OP_PUSH,
                      $urandom, 5'($urandom_range(31)));
         // drain: mostly pops
         while (list_count > 0) begin
            pick = $urandom_range(99);
            if (pick < 80)
               send_item(olip_pkg::OP_POP, $urandom, 5'($urandom_range(31)));
            else if (pick < 90)
               send_item(olip_pkg::OP_PUSH, $urandom, 5'($urandom_range(31)));
            else if (pick < 95)
               send_item(olip_pkg::OP_INSERT, $urandom, pick_position());
            else
               send_item(olip_pkg::OP_NOP, $urandom, 5'($urandom_range(31)));
         end
         repeat ($urandom_range(3, 1))
            send_item(olip_pkg::OP_POP, $urandom, 5'($urandom_range(31)));
      end
   endtask

   // Full rate on both sides: no sender gaps, no result stalls.
   task automatic test_back_to_back(int n_items);
      idle_on = 1'b0;
      test_fill_drain(n_items);
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(600);
      // hold the sender until the block has answered everything
      hold_until_drained();
      test_fill_drain(700);
      test_back_to_back(230);

      hold_until_drained();
      // allow for a late, unexpected item after the last expected one
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0)
         $display("ordered_list_insert_pop_test passed");
      else
         $display("ordered_list_insert_pop_test failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2_000_000;
      $display("ordered_list_insert_pop_test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/olip_pkg.sv
rtl/olip_ctrl.sv
rtl/olip_dpath.sv
rtl/ordered_list_insert_pop.sv
verif/ordered_list_insert_pop_test.sv
